// ----- rtl/clbs_pkg.sv -----
// ----------------------------------------------------------------------------
// clbs_pkg
// Shared widths, codes and types of the cell list bucket sort.
// ----------------------------------------------------------------------------
package clbs_pkg;

   localparam int ATOM_W   = 12;
   localparam int BIN_W    = 10;
   localparam int CNT_W    = 13;
   localparam int CFG_W    = 11;
   localparam int REQ_W    = 2;
   localparam int STATUS_W = 2;

   localparam int MAX_ATOMS_DEFAULT = 4096;
   localparam int MAX_BINS_DEFAULT  = 1024;

   localparam logic [CFG_W-1:0] BINS_IN_USE_RESET = 11'd1024;

   typedef enum logic [REQ_W-1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_READ   = 2'd2
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_RANGE   = 2'd1,
      ST_DONE    = 2'd2,
      ST_REFUSED = 2'd3
   } status_type;

   // One word of the head store or the link store: a valid flag and an atom.
   typedef struct packed {
      logic              ok;
      logic [ATOM_W-1:0] val;
   } entry_type;

   typedef struct packed {
      logic rd;
      logic wr;
      logic clr;
   } head_cmd_type;

endpackage

// ----- rtl/clbs_head_store.sv -----
// ----------------------------------------------------------------------------
// clbs_head_store
// Head entry of every bin, with a sweep that empties all entries after reset
// and on a clear command.
// ----------------------------------------------------------------------------
module clbs_head_store #(
   parameter int MAX_BINS = clbs_pkg::MAX_BINS_DEFAULT,
   localparam int BIN_AW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  clbs_pkg::head_cmd_type cmd,
   input  logic [BIN_AW-1:0]      rd_addr,
   input  logic [BIN_AW-1:0]      wr_addr,
   input  clbs_pkg::entry_type    wr_data,
   output clbs_pkg::entry_type    rd_data,
   output logic                   busy
);

   localparam logic [BIN_AW-1:0] SWEEP_END = BIN_AW'(MAX_BINS - 1);

   clbs_pkg::entry_type head_mem [MAX_BINS];
   clbs_pkg::entry_type rd_data_ff;

   logic              sweep_ff;
   logic              sweep_in;
   logic [BIN_AW-1:0] ptr_ff;
   logic [BIN_AW-1:0] ptr_in;

   logic                wr_en;
   logic [BIN_AW-1:0]   wr_sel;
   clbs_pkg::entry_type wr_word;

   always_comb begin
      sweep_in = sweep_ff;
      ptr_in   = ptr_ff;
      if (cmd.clr) begin
         sweep_in = 1'b1;
         ptr_in   = '0;
      end else if (sweep_ff) begin
         if (ptr_ff == SWEEP_END) begin
            sweep_in = 1'b0;
         end else begin
            ptr_in = ptr_ff + 1'b1;
         end
      end
   end

   // The sweep owns the write port while it runs.
   assign wr_en   = sweep_ff || cmd.wr;
   assign wr_sel  = sweep_ff ? ptr_ff : wr_addr;
   assign wr_word = sweep_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= 1'b1;
         ptr_ff   <= '0;
      end else begin
         sweep_ff <= sweep_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         head_mem[wr_sel] <= wr_word;
      end
      if (cmd.rd) begin
         rd_data_ff <= head_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = sweep_ff;

endmodule

// ----- rtl/clbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// clbs_ctrl
// Sequencer for insert, clear and packed readout, holding the per-atom link
// store and the result register.
// ----------------------------------------------------------------------------
module clbs_ctrl #(
   parameter int MAX_ATOMS = clbs_pkg::MAX_ATOMS_DEFAULT,
   parameter int MAX_BINS  = clbs_pkg::MAX_BINS_DEFAULT,
   localparam int BIN_AW   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [clbs_pkg::REQ_W-1:0]      req_type,
   input  logic [clbs_pkg::ATOM_W-1:0]     req_atom_index,
   input  logic [clbs_pkg::BIN_W-1:0]      req_bin_index,
   input  logic [clbs_pkg::CFG_W-1:0]      eff_bins,
   output clbs_pkg::head_cmd_type          head_cmd,
   output logic [BIN_AW-1:0]               head_rd_addr,
   output logic [BIN_AW-1:0]               head_wr_addr,
   output clbs_pkg::entry_type             head_wr_data,
   input  clbs_pkg::entry_type             head_rd_data,
   input  logic                            head_busy,
   output logic                            rsp_valid,
   output logic [clbs_pkg::ATOM_W-1:0]     rsp_packed_atom,
   output logic [clbs_pkg::BIN_W-1:0]      rsp_packed_bin,
   output logic [clbs_pkg::CNT_W-1:0]      rsp_bin_start,
   output logic                            rsp_entry_valid,
   output logic                            rsp_done_res,
   output logic [clbs_pkg::STATUS_W-1:0]   rsp_status
);

   localparam int ATOM_AW = $clog2(MAX_ATOMS);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_INS     = 6'b000010,
      S_CLR     = 6'b000100,
      S_RD_STEP = 6'b001000,
      S_RD_HEAD = 6'b010000,
      S_RD_LINK = 6'b100000
   } state_type;

   typedef struct packed {
      logic [clbs_pkg::ATOM_W-1:0]   atom;
      logic [clbs_pkg::BIN_W-1:0]    bin;
      logic [clbs_pkg::CNT_W-1:0]    start;
      logic                          entry_valid;
      logic                          done;
      logic [clbs_pkg::STATUS_W-1:0] status;
   } result_type;

   state_type state_ff, state_in;

   logic [clbs_pkg::ATOM_W-1:0] atom_ff, atom_in;
   logic [clbs_pkg::BIN_W-1:0]  bin_ff, bin_in;
   logic [clbs_pkg::CFG_W-1:0]  read_bin_ff, read_bin_in;
   logic [clbs_pkg::ATOM_W-1:0] read_link_ff, read_link_in;
   logic                        link_ok_ff, link_ok_in;
   logic [clbs_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [clbs_pkg::CNT_W-1:0]  cur_start_ff, cur_start_in;
   logic                        active_ff, active_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   result_type                  rsp_ff, rsp_in;

   clbs_pkg::entry_type link_mem [MAX_ATOMS];
   clbs_pkg::entry_type link_q_ff;

   logic                link_rd;
   logic [ATOM_AW-1:0]  link_rd_addr;
   logic                link_wr;
   logic [ATOM_AW-1:0]  link_wr_addr;
   clbs_pkg::entry_type link_wr_data;

   logic accept;
   logic emit_now;

   assign busy   = (state_ff != S_IDLE) || head_busy;
   assign accept = start && !busy;

   // An entry goes out either straight from an accepted read whose list is
   // still open, or from the scan once a non-empty head has been loaded.
   assign emit_now = link_ok_ff &&
                     ((state_ff == S_RD_STEP) ||
                      (state_ff == S_IDLE && accept && active_ff &&
                       req_type == clbs_pkg::REQ_READ));

   always_comb begin
      state_in     = state_ff;
      atom_in      = atom_ff;
      bin_in       = bin_ff;
      read_bin_in  = read_bin_ff;
      read_link_in = read_link_ff;
      link_ok_in   = link_ok_ff;
      count_in     = count_ff;
      cur_start_in = cur_start_ff;
      active_in    = active_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      head_cmd     = '0;
      head_rd_addr = BIN_AW'(req_bin_index);
      head_wr_addr = BIN_AW'(bin_ff);
      head_wr_data = '{ok: 1'b1, val: atom_ff};
      link_rd      = 1'b0;
      link_rd_addr = ATOM_AW'(read_link_ff);
      link_wr      = 1'b0;
      link_wr_addr = ATOM_AW'(atom_ff);
      link_wr_data = head_rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  clbs_pkg::REQ_CLEAR: begin
                     head_cmd.clr = 1'b1;
                     read_bin_in  = '0;
                     link_ok_in   = 1'b0;
                     count_in     = '0;
                     cur_start_in = '0;
                     active_in    = 1'b0;
                     state_in     = S_CLR;
                  end
                  clbs_pkg::REQ_INSERT: begin
                     if (active_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = clbs_pkg::ST_REFUSED;
                     end else if (({1'b0, req_bin_index} >= eff_bins) ||
                                  (int'(req_atom_index) >= MAX_ATOMS)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = clbs_pkg::ST_RANGE;
                     end else begin
                        head_cmd.rd = 1'b1;
                        atom_in     = req_atom_index;
                        bin_in      = req_bin_index;
                        state_in    = S_INS;
                     end
                  end
                  clbs_pkg::REQ_READ: begin
                     if (!active_ff) begin
                        read_bin_in  = '0;
                        link_ok_in   = 1'b0;
                        count_in     = '0;
                        cur_start_in = '0;
                        active_in    = 1'b1;
                        state_in     = S_RD_STEP;
                     end else if (!link_ok_ff) begin
                        state_in = S_RD_STEP;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_INS: begin
            // Push the atom in front of the old head of its bin.
            link_wr      = 1'b1;
            head_cmd.wr  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_CLR: begin
            if (!head_busy) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_RD_STEP: begin
            if (!link_ok_ff) begin
               if (read_bin_ff >= eff_bins) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.start  = count_ff;
                  rsp_in.done   = 1'b1;
                  rsp_in.status = clbs_pkg::ST_DONE;
                  state_in      = S_IDLE;
               end else begin
                  head_cmd.rd  = 1'b1;
                  head_rd_addr = BIN_AW'(read_bin_ff);
                  state_in     = S_RD_HEAD;
               end
            end
         end
         S_RD_HEAD: begin
            if (head_rd_data.ok) begin
               read_link_in = head_rd_data.val;
               link_ok_in   = 1'b1;
               cur_start_in = count_ff;
            end else begin
               read_bin_in = read_bin_ff + 1'b1;
            end
            state_in = S_RD_STEP;
         end
         S_RD_LINK: begin
            read_link_in = link_q_ff.val;
            link_ok_in   = link_q_ff.ok;
            if (!link_q_ff.ok) begin
               read_bin_in = read_bin_ff + 1'b1;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit_now) begin
         rsp_valid_in       = 1'b1;
         rsp_in.atom        = read_link_ff;
         rsp_in.bin         = read_bin_ff[clbs_pkg::BIN_W-1:0];
         rsp_in.start       = cur_start_ff;
         rsp_in.entry_valid = 1'b1;
         count_in           = count_ff + 1'b1;
         if (int'(read_link_ff) < MAX_ATOMS) begin
            link_rd  = 1'b1;
            state_in = S_RD_LINK;
         end else begin
            link_ok_in  = 1'b0;
            read_bin_in = read_bin_ff + 1'b1;
            state_in    = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         read_bin_ff  <= '0;
         read_link_ff <= '0;
         link_ok_ff   <= 1'b0;
         count_ff     <= '0;
         cur_start_ff <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         read_bin_ff  <= read_bin_in;
         read_link_ff <= read_link_in;
         link_ok_ff   <= link_ok_in;
         count_ff     <= count_in;
         cur_start_ff <= cur_start_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      atom_ff <= atom_in;
      bin_ff  <= bin_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (link_wr) begin
         link_mem[link_wr_addr] <= link_wr_data;
      end
      if (link_rd) begin
         link_q_ff <= link_mem[link_rd_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_packed_atom = rsp_ff.atom;
   assign rsp_packed_bin  = rsp_ff.bin;
   assign rsp_bin_start   = rsp_ff.start;
   assign rsp_entry_valid = rsp_ff.entry_valid;
   assign rsp_done_res    = rsp_ff.done;
   assign rsp_status      = rsp_ff.status;

endmodule

// ----- rtl/cell_list_bucket_sort.sv -----
// ----------------------------------------------------------------------------
// cell_list_bucket_sort
// Bucket sort of atoms into per-bin linked lists with packed readout.
// ----------------------------------------------------------------------------
// After reset the block is busy while it empties the head store, one bin
// per cycle; a clear item repeats that sweep. An insert is a
// read-modify-write of the head store and a write of the link store; a
// refused, out of range or unused item is answered straight from idle. A
// read that continues an open list emits its entry and then reads the next
// link from the link store. A read that must find a new list reads the head
// store bin by bin, skipping empty bins, and emits the first entry of the
// next non-empty bin, or a done result past the last bin in use. Each
// result appears on the rsp_ ports for one cycle after its work completes
// and the receiver cannot stall it, so it must take every rsp_valid pulse.
module cell_list_bucket_sort #(
   parameter int MAX_ATOMS = clbs_pkg::MAX_ATOMS_DEFAULT,
   parameter int MAX_BINS  = clbs_pkg::MAX_BINS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [clbs_pkg::REQ_W-1:0]    req_type,
   input  logic [clbs_pkg::ATOM_W-1:0]   req_atom_index,
   input  logic [clbs_pkg::BIN_W-1:0]    req_bin_index,
   input  logic                          csr_wr_en,
   input  logic [clbs_pkg::CFG_W-1:0]    csr_wr_data,
   output logic                          rsp_valid,
   output logic [clbs_pkg::ATOM_W-1:0]   rsp_packed_atom,
   output logic [clbs_pkg::BIN_W-1:0]    rsp_packed_bin,
   output logic [clbs_pkg::CNT_W-1:0]    rsp_bin_start,
   output logic                          rsp_entry_valid,
   output logic                          rsp_done_res,
   output logic [clbs_pkg::STATUS_W-1:0] rsp_status
);

   localparam int BIN_AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

   logic [clbs_pkg::CFG_W-1:0] bins_ff;
   logic [clbs_pkg::CFG_W-1:0] bins_in;
   logic [clbs_pkg::CFG_W-1:0] eff_bins;

   clbs_pkg::head_cmd_type head_cmd;
   logic [BIN_AW-1:0]      head_rd_addr;
   logic [BIN_AW-1:0]      head_wr_addr;
   clbs_pkg::entry_type    head_wr_data;
   clbs_pkg::entry_type    head_rd_data;
   logic                   head_busy;

   assign bins_in  = csr_wr_en ? csr_wr_data : bins_ff;

   // Bins in use never exceed the depth of the head store.
   assign eff_bins = (int'(bins_ff) > MAX_BINS) ? clbs_pkg::CFG_W'(MAX_BINS) : bins_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bins_ff <= clbs_pkg::BINS_IN_USE_RESET;
      end else begin
         bins_ff <= bins_in;
      end
   end

   clbs_head_store #(
      .MAX_BINS (MAX_BINS)
   ) u_head (
      .clock   (clock),
      .reset   (reset),
      .cmd     (head_cmd),
      .rd_addr (head_rd_addr),
      .wr_addr (head_wr_addr),
      .wr_data (head_wr_data),
      .rd_data (head_rd_data),
      .busy    (head_busy)
   );

   clbs_ctrl #(
      .MAX_ATOMS (MAX_ATOMS),
      .MAX_BINS  (MAX_BINS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_atom_index  (req_atom_index),
      .req_bin_index   (req_bin_index),
      .eff_bins        (eff_bins),
      .head_cmd        (head_cmd),
      .head_rd_addr    (head_rd_addr),
      .head_wr_addr    (head_wr_addr),
      .head_wr_data    (head_wr_data),
      .head_rd_data    (head_rd_data),
      .head_busy       (head_busy),
      .rsp_valid       (rsp_valid),
      .rsp_packed_atom (rsp_packed_atom),
      .rsp_packed_bin  (rsp_packed_bin),
      .rsp_bin_start   (rsp_bin_start),
      .rsp_entry_valid (rsp_entry_valid),
      .rsp_done_res    (rsp_done_res),
      .rsp_status      (rsp_status)
   );

endmodule

// ----- rtl/clbs_checker.sv -----
// ----------------------------------------------------------------------------
// clbs_checker
// Port-level checks of the cell list bucket sort, bound to the top level.
// ----------------------------------------------------------------------------
module clbs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [clbs_pkg::ATOM_W-1:0]   rsp_packed_atom,
   input logic [clbs_pkg::BIN_W-1:0]    rsp_packed_bin,
   input logic                          rsp_entry_valid,
   input logic                          rsp_done_res,
   input logic [clbs_pkg::STATUS_W-1:0] rsp_status
);

   // A result only follows a cycle in which an item was taken or in work.
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("result without an item in work");

   // A done result carries no entry and always the done status.
   a_done_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |->
         (!rsp_entry_valid && rsp_status == clbs_pkg::ST_DONE))
      else $error("done result with a wrong status");

   a_entry_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_entry_valid) |-> (rsp_status == clbs_pkg::ST_OK))
      else $error("packed entry with a non-ok status");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_entry_valid) |->
         (rsp_packed_atom == '0 && rsp_packed_bin == '0))
      else $error("non-entry result carries an atom or bin");

endmodule

bind cell_list_bucket_sort clbs_checker u_clbs_checker (.*);
